// File: rtl/grfm_pkg.sv
package grfm_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_GRID_SIDE   = 16;
    localparam int DEF_ANGLE_STEPS = 4096;
    localparam int DEF_FRAC_BITS   = 12;
    localparam int DEF_MAX_RAYS    = 64;

    // Fixed field widths.
    localparam int REG_W    = 12;
    localparam int CNT_W    = 7;
    localparam int RAY_W    = 6;
    localparam int HIT_W    = 18;
    localparam int STEP_W   = 13;
    localparam int PHASE_W  = 16;
    localparam int CFG_AW   = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    // Opcodes carried on the input tuser bit.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_RAY_COUNT   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_RAY_SPACING = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HALF_FOV    = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_STEP_LEN    = 2'd3;

    // Configuration reset values.
    localparam logic [CNT_W-1:0] RST_RAY_COUNT   = 7'd60;
    localparam logic [REG_W-1:0] RST_RAY_SPACING = 12'd11;
    localparam logic [REG_W-1:0] RST_HALF_FOV    = 12'd683;
    localparam logic [REG_W-1:0] RST_STEP_LEN    = 12'd410;

    // Request to the step generator: one phase and the step length.
    typedef struct packed {
        logic               start;
        logic [PHASE_W-1:0] phase;
        logic [REG_W-1:0]   len;
    } sg_req_t;

    // Answer of the step generator: a one-cycle done pulse and the signed step.
    typedef struct packed {
        logic                     done;
        logic signed [STEP_W-1:0] step;
    } sg_rsp_t;

endpackage

// File: rtl/grfm_step_gen.sv
module grfm_step_gen #(
    parameter int FRAC_BITS = grfm_pkg::DEF_FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  grfm_pkg::sg_req_t req,
    output grfm_pkg::sg_rsp_t rsp
);
    import grfm_pkg::*;

    // Sine polynomial in Q14, evaluated on one shared multiplier.
    localparam int Q     = 14;
    localparam int T_W   = 15;
    localparam int R_W   = FRAC_BITS + 1;
    localparam int OPA_W = (R_W > T_W) ? R_W : T_W;
    localparam int OPB_W = T_W;
    localparam int PRD_W = OPA_W + OPB_W;
    localparam int SUM_W = T_W + 1 + FRAC_BITS;

    localparam logic [T_W-1:0] C_QUARTER = 15'd16384;
    localparam logic [T_W-1:0] C_K1      = 15'd1232;
    localparam logic [T_W-1:0] C_K3      = 15'd10584;
    localparam logic [T_W-1:0] C_K5      = 15'd25736;
    localparam logic [SUM_W-1:0] C_HALF_Q = SUM_W'(8192);
    localparam logic [PRD_W:0]   C_HALF_F = (PRD_W + 1)'(1) << (FRAC_BITS - 1);

    localparam logic [2:0] SG_IDLE = 3'd0;
    localparam logic [2:0] SG_SQ   = 3'd1;
    localparam logic [2:0] SG_A    = 3'd2;
    localparam logic [2:0] SG_C    = 3'd3;
    localparam logic [2:0] SG_S    = 3'd4;
    localparam logic [2:0] SG_M    = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic                     done_reg;
    logic [T_W-1:0]           t_reg, t2_reg, v_reg;
    logic [R_W-1:0]           r_reg;
    logic [REG_W-1:0]         len_reg;
    logic                     neg_reg;
    logic signed [STEP_W-1:0] step_reg;

    logic [OPA_W-1:0] op_a;
    logic [OPB_W-1:0] op_b;
    logic [PRD_W-1:0] prod;
    logic [T_W-1:0]   prod_q;
    logic [SUM_W-1:0] s_sum;
    logic [PRD_W:0]   m_rnd;
    logic [REG_W-1:0] mag;
    logic [T_W-1:0]   t_in;

    // Fold the phase into the first quadrant.
    assign t_in = req.phase[Q] ? (C_QUARTER - {1'b0, req.phase[Q-1:0]})
                               : {1'b0, req.phase[Q-1:0]};

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (state_reg)
            SG_SQ: begin
                op_a = OPA_W'(t_reg);
                op_b = t_reg;
            end
            SG_A: begin
                op_a = OPA_W'(t2_reg);
                op_b = C_K1;
            end
            SG_C: begin
                op_a = OPA_W'(t2_reg);
                op_b = v_reg;
            end
            SG_S: begin
                op_a = OPA_W'(t_reg);
                op_b = v_reg;
            end
            SG_M: begin
                op_a = OPA_W'(r_reg);
                op_b = OPB_W'(len_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod   = PRD_W'(op_a) * PRD_W'(op_b);
    assign prod_q = prod[Q +: T_W];
    // Rescale the Q14 sine to FRAC_BITS with rounding.
    assign s_sum  = (SUM_W'(prod_q) << FRAC_BITS) + C_HALF_Q;
    // Round the scaled step to nearest, half away from zero.
    assign m_rnd  = {1'b0, prod} + C_HALF_F;
    assign mag    = m_rnd[FRAC_BITS +: REG_W];

    // Sequencer: one multiplication per cycle.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SG_IDLE: if (req.start) state_next = SG_SQ;
            SG_SQ:   state_next = SG_A;
            SG_A:    state_next = SG_C;
            SG_C:    state_next = SG_S;
            SG_S:    state_next = SG_M;
            SG_M:    state_next = SG_IDLE;
            default: state_next = SG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SG_M);
        end
    end

    // Working registers of the polynomial.
    always_ff @(posedge aclk) begin
        case (state_reg)
            SG_IDLE: begin
                t_reg   <= t_in;
                neg_reg <= req.phase[Q+1];
                len_reg <= req.len;
            end
            SG_SQ: t2_reg <= prod_q;
            SG_A:  v_reg  <= C_K3 - prod_q;
            SG_C:  v_reg  <= C_K5 - prod_q;
            SG_S:  r_reg  <= s_sum[Q +: R_W];
            SG_M: begin
                if (neg_reg) begin
                    step_reg <= -$signed({1'b0, mag});
                end else begin
                    step_reg <= $signed({1'b0, mag});
                end
            end
            default: ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.step = step_reg;

endmodule

// File: rtl/grid_ray_fan_march_top.sv
// Channel   Direction  Handshake                Content
// s_        in         s_tvalid / s_tready      cell write or cast request
// m_        out        m_tvalid / m_tready      one hit point per ray
// cfg_      in         cfg_wr_en (no wait)      ray count, spacing, half fov, step length
//
// Each ray of a cast first runs the shared sine/step multiplier twice, for the cosine
// and then the sine, and takes its first step; it then marches one step per cycle, set
// by the registered wall read, and offers its hit point.
// Reset is synchronous; it restores the configuration and control registers and clears all wall valid bits at once.
// The input is not ready while a cast runs, and a hit point waits for m_tready.
module grid_ray_fan_march_top #(
    parameter int GRID_SIDE   = grfm_pkg::DEF_GRID_SIDE,
    parameter int ANGLE_STEPS = grfm_pkg::DEF_ANGLE_STEPS,
    parameter int FRAC_BITS   = grfm_pkg::DEF_FRAC_BITS,
    parameter int MAX_RAYS    = grfm_pkg::DEF_MAX_RAYS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: cell_row[3:0], cell_col[7:4], cell_is_wall[8], start_x[24:9],
    //          start_y[40:25], heading[52:41], zero pad[55:53]
    input  logic [grfm_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: opcode[0]
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: ray_index[5:0], hit_x[23:6], hit_y[41:24], zero pad[47:42]
    output logic [grfm_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  logic [grfm_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [grfm_pkg::REG_W-1:0]    cfg_wr_data
);
    import grfm_pkg::*;

    // ANGLE_STEPS is a power of two; angles wrap by masking.
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int ANG_W = $clog2(ANGLE_STEPS);
    localparam int POS_W = ((CW + FRAC_BITS > 16) ? CW + FRAC_BITS : 16) + 2;
    localparam int GUARD = (GRID_SIDE + 2) << FRAC_BITS;
    localparam int GD_W  = $clog2(GUARD + 1);

    localparam logic [PHASE_W-1:0] PH_QUARTER = PHASE_W'(16384);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_COS_GO   = 3'd1;
    localparam logic [2:0] ST_COS_WAIT = 3'd2;
    localparam logic [2:0] ST_SIN_GO   = 3'd3;
    localparam logic [2:0] ST_SIN_WAIT = 3'd4;
    localparam logic [2:0] ST_ADV      = 3'd5;
    localparam logic [2:0] ST_MARCH    = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    // Reduce a 12-bit angle field modulo ANGLE_STEPS.
    function automatic logic [ANG_W-1:0] to_ang(input logic [REG_W-1:0] v);
        logic [ANG_W+REG_W-1:0] ext;
        ext = {{ANG_W{1'b0}}, v};
        return ext[ANG_W-1:0];
    endfunction

    // Configuration registers.
    logic [CNT_W-1:0] ray_count_reg;
    logic [REG_W-1:0] ray_spacing_reg, half_fov_reg, step_len_reg;

    // Control state.
    logic [2:0]       state_reg, state_next;
    logic [RAY_W-1:0] ray_k_reg, last_k_reg;
    logic [GD_W-1:0]  steps_reg;

    // Per-cast payload.
    logic [ANG_W-1:0]         ang_reg;
    logic [REG_W-1:0]         len_reg;
    logic [POS_W-1:0]         start_x_reg, start_y_reg;
    logic signed [STEP_W-1:0] dx_reg, dy_reg;
    logic [POS_W-1:0]         x_reg, y_reg;

    // Wall memory with a valid bit per cell.
    logic             wall_mem [CELLS];
    logic [CELLS-1:0] wall_vld_reg;
    logic             rd_wall_reg, rd_vld_reg;

    // Input fields.
    logic [3:0]        in_row, in_col;
    logic              in_wall;
    logic [15:0]       in_x, in_y;
    logic [REG_W-1:0]  in_heading;
    logic              in_accept, out_accept;
    logic              wr_ok;
    logic [AW-1:0]     wr_addr;
    logic [RAY_W-1:0]  last_k_in;

    logic [POS_W-1:0] x_base, y_base, x_sum, y_sum;
    logic [CW-1:0]    cx, cy;
    logic [AW-1:0]    rd_addr;
    logic             x_oob, y_oob, blocked, advance;
    logic [PHASE_W-1:0] phase;

    sg_req_t sg_req;
    sg_rsp_t sg_rsp;

    assign in_row     = s_tdata[3:0];
    assign in_col     = s_tdata[7:4];
    assign in_wall    = s_tdata[8];
    assign in_x       = s_tdata[24:9];
    assign in_y       = s_tdata[40:25];
    assign in_heading = s_tdata[52:41];

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign m_tvalid   = (state_reg == ST_EMIT);
    assign out_accept = m_tvalid && m_tready;

    // Cell write address; writes outside the grid are dropped.
    assign wr_ok   = (32'(in_row) < GRID_SIDE) && (32'(in_col) < GRID_SIDE);
    assign wr_addr = AW'(32'(in_row) * GRID_SIDE + 32'(in_col));

    // Fan size clamped to one through MAX_RAYS.
    always_comb begin
        if (ray_count_reg == '0) begin
            last_k_in = '0;
        end else if (32'(ray_count_reg) > MAX_RAYS) begin
            last_k_in = RAY_W'(MAX_RAYS - 1);
        end else begin
            last_k_in = RAY_W'(ray_count_reg - CNT_W'(1));
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ray_count_reg   <= RST_RAY_COUNT;
            ray_spacing_reg <= RST_RAY_SPACING;
            half_fov_reg    <= RST_HALF_FOV;
            step_len_reg    <= RST_STEP_LEN;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_RAY_COUNT:   ray_count_reg   <= cfg_wr_data[CNT_W-1:0];
                CFG_RAY_SPACING: ray_spacing_reg <= cfg_wr_data;
                CFG_HALF_FOV:    half_fov_reg    <= cfg_wr_data;
                CFG_STEP_LEN:    step_len_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Step generator shared by the cosine and the sine of each ray.
    assign phase = PHASE_W'({ang_reg, {PHASE_W{1'b0}}} >> ANG_W);

    assign sg_req.start = (state_reg == ST_COS_GO) || (state_reg == ST_SIN_GO);
    assign sg_req.phase = (state_reg == ST_COS_GO) ? (phase + PH_QUARTER) : phase;
    assign sg_req.len   = len_reg;

    grfm_step_gen #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sg_req),
        .rsp     (sg_rsp)
    );

    // March datapath: next point and the cell address it reads.
    assign x_base = (state_reg == ST_ADV) ? start_x_reg : x_reg;
    assign y_base = (state_reg == ST_ADV) ? start_y_reg : y_reg;
    assign x_sum  = x_base + {{(POS_W-STEP_W){dx_reg[STEP_W-1]}}, dx_reg};
    assign y_sum  = y_base + {{(POS_W-STEP_W){dy_reg[STEP_W-1]}}, dy_reg};
    assign cx     = x_sum[FRAC_BITS +: CW];
    assign cy     = y_sum[FRAC_BITS +: CW];
    assign rd_addr = AW'(32'(cy) * GRID_SIDE + 32'(cx));

    // Test of the current point, whose cell was read in the cycle before.
    assign x_oob   = x_reg[POS_W-1] || (32'(x_reg[POS_W-2:FRAC_BITS]) >= GRID_SIDE);
    assign y_oob   = y_reg[POS_W-1] || (32'(y_reg[POS_W-2:FRAC_BITS]) >= GRID_SIDE);
    assign blocked = x_oob || y_oob || (rd_wall_reg && rd_vld_reg)
                     || (steps_reg == GD_W'(GUARD));
    assign advance = (state_reg == ST_ADV) || ((state_reg == ST_MARCH) && !blocked);

    // Wall memory: one write port for cell items, one registered read for the march.
    always_ff @(posedge aclk) begin
        if (in_accept && (s_tuser == OP_WRITE) && wr_ok) begin
            wall_mem[wr_addr] <= in_wall;
        end
        rd_wall_reg <= wall_mem[rd_addr];
        rd_vld_reg  <= wall_vld_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_vld_reg <= '0;
        end else if (in_accept && (s_tuser == OP_WRITE) && wr_ok) begin
            wall_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Sequencer over rays and march steps.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_accept && (s_tuser == OP_CAST)) state_next = ST_COS_GO;
            ST_COS_GO:   state_next = ST_COS_WAIT;
            ST_COS_WAIT: if (sg_rsp.done) state_next = ST_SIN_GO;
            ST_SIN_GO:   state_next = ST_SIN_WAIT;
            ST_SIN_WAIT: if (sg_rsp.done) state_next = ST_ADV;
            ST_ADV:      state_next = ST_MARCH;
            ST_MARCH:    if (blocked) state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_accept) begin
                    state_next = (ray_k_reg == last_k_reg) ? ST_IDLE : ST_COS_GO;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ray_k_reg  <= '0;
            last_k_reg <= '0;
            steps_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (in_accept) begin
                ray_k_reg  <= '0;
                last_k_reg <= last_k_in;
            end else if (out_accept) begin
                ray_k_reg <= ray_k_reg + RAY_W'(1);
            end
            if (state_reg == ST_SIN_WAIT) begin
                steps_reg <= '0;
            end else if (advance) begin
                steps_reg <= steps_reg + GD_W'(1);
            end
        end
    end

    // Per-cast and per-ray payload.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ang_reg     <= to_ang(in_heading) - to_ang(half_fov_reg);
            len_reg     <= (step_len_reg == '0) ? REG_W'(1) : step_len_reg;
            start_x_reg <= POS_W'(in_x);
            start_y_reg <= POS_W'(in_y);
        end else if (out_accept) begin
            ang_reg <= ang_reg + to_ang(ray_spacing_reg);
        end
        if ((state_reg == ST_COS_WAIT) && sg_rsp.done) begin
            dx_reg <= sg_rsp.step;
        end
        if ((state_reg == ST_SIN_WAIT) && sg_rsp.done) begin
            dy_reg <= sg_rsp.step;
        end
        if (advance) begin
            x_reg <= x_sum;
            y_reg <= y_sum;
        end
    end

    // Result item.
    assign m_tdata = {{(M_DATA_W - RAY_W - 2 * HIT_W){1'b0}},
                      y_reg[HIT_W-1:0], x_reg[HIT_W-1:0], ray_k_reg};
    assign m_tlast = (ray_k_reg == last_k_reg);

    // A result is never offered while a new item can be taken.
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // An accepted cast starts the first ray's setup.
    a_cast_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_CAST)) |=> (state_reg == ST_COS_GO))
        else $error("cast item did not start the ray setup");

    // The step generator only answers while the sequencer waits for it.
    a_sg_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sg_rsp.done |-> ((state_reg == ST_COS_WAIT) || (state_reg == ST_SIN_WAIT)))
        else $error("step generator answered outside a wait state");

    // Every emitted point lies at least one step from the viewer.
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (steps_reg != '0))
        else $error("hit point emitted without a march step");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import grfm_pkg::*;

    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int GUARD_STEPS  = 18 << 12;
    localparam int SETTLE_GAP   = 20;

    // One expected hit point: ray index, hit coordinates and the last flag.
    typedef struct packed {
        logic [RAY_W-1:0] ray;
        logic [HIT_W-1:0] x;
        logic [HIT_W-1:0] y;
        logic             last;
    } hit_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic                  s_tuser     = OP_WRITE;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0]     cfg_addr    = CFG_RAY_COUNT;
    logic [REG_W-1:0]      cfg_wr_data = '0;

    // Shadow copy of the block's registers and wall grid.
    logic [CNT_W-1:0] fan_rays     = RST_RAY_COUNT;
    logic [REG_W-1:0] fan_spacing  = RST_RAY_SPACING;
    logic [REG_W-1:0] fan_half_fov = RST_HALF_FOV;
    logic [REG_W-1:0] fan_step     = RST_STEP_LEN;
    bit               wall_map [0:255];

    hit_t hits_due [$];
    int   errors    = 0;
    int   cycles    = 0;
    int   hold_left = 0;
    bit   quiet     = 1'b0;

    grid_ray_fan_march_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Sine of a 16-bit phase in Q.12, from the polynomial of the block.
    function automatic longint trig_q12(input logic [PHASE_W-1:0] ph);
        logic [1:0] quad;
        longint     t;
        longint     t2;
        longint     s;
        longint     r;
        quad = ph[15:14];
        t    = longint'(ph[13:0]);
        if (quad[0]) begin
            t = 16384 - t;
        end
        t2 = (t * t) >>> 14;
        s  = (t * (25736 - ((t2 * (10584 - ((t2 * 1232) >>> 14))) >>> 14))) >>> 14;
        r  = ((s <<< 12) + 8192) >>> 14;
        return quad[1] ? -r : r;
    endfunction

    // One step component: trig times length, rounded half away from zero.
    function automatic longint step_part(input longint trig, input longint len);
        longint m;
        longint r;
        m = (trig < 0 ? -trig : trig) * len;
        r = (m + 2048) >>> 12;
        return trig < 0 ? -r : r;
    endfunction

    // Points off the grid count as walls.
    function automatic bit blocked(input longint x, input longint y);
        if (x < 0 || y < 0) begin
            return 1'b1;
        end
        if ((x >>> 12) >= 16 || (y >>> 12) >= 16) begin
            return 1'b1;
        end
        return wall_map[(y >>> 12) * 16 + (x >>> 12)];
    endfunction

    // March every ray of one cast and queue its stopping point.
    function automatic void trace_fan(input logic [15:0] x0, input logic [15:0] y0,
                                      input logic [11:0] hd);
        int               n;
        longint           len;
        longint           fov;
        longint           base;
        longint           ang;
        longint           dx;
        longint           dy;
        longint           x;
        longint           y;
        longint           steps;
        logic [PHASE_W-1:0] ph;
        logic [PHASE_W-1:0] cph;
        hit_t             h;
        n = int'(fan_rays);
        if (n == 0) begin
            n = 1;
        end
        if (n > 64) begin
            n = 64;
        end
        len  = (fan_step == 0) ? 1 : longint'(fan_step);
        fov  = longint'(fan_half_fov);
        base = (longint'(hd) + 4096 - fov) % 4096;
        for (int k = 0; k < n; k++) begin
            ang   = (base + k * longint'(fan_spacing)) % 4096;
            ph    = PHASE_W'(ang * 16);
            cph   = ph + 16'h4000;
            dx    = step_part(trig_q12(cph), len);
            dy    = step_part(trig_q12(ph), len);
            x     = longint'(x0);
            y     = longint'(y0);
            steps = 0;
            do begin
                x = x + dx;
                y = y + dy;
                steps++;
            end while (!blocked(x, y) && steps < GUARD_STEPS);
            h.ray  = k[RAY_W-1:0];
            h.x    = x[HIT_W-1:0];
            h.y    = y[HIT_W-1:0];
            h.last = (k + 1 == n);
            hits_due.push_back(h);
        end
    endfunction

    // Offer one item, with a random gap first unless idling is off.
    task automatic send_item(input logic op, input logic [3:0] row, input logic [3:0] col,
                             input logic wall, input logic [15:0] x, input logic [15:0] y,
                             input logic [11:0] hd);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap      = $urandom_range(1, 16);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {3'b000, hd, y, x, wall, col, row};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_cell(input logic [3:0] row, input logic [3:0] col, input logic wall);
        wall_map[{row, col}] = wall;
        send_item(OP_WRITE, row, col, wall, 16'($urandom), 16'($urandom), 12'($urandom));
    endtask

    task automatic send_cast(input logic [15:0] x, input logic [15:0] y,
                             input logic [11:0] hd);
        trace_fan(x, y, hd);
        send_item(OP_CAST, 4'($urandom), 4'($urandom), 1'($urandom), x, y, hd);
    endtask

    // Stop offering and wait until every hit has come and the block is quiet.
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (hits_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        case (idx)
            CFG_RAY_COUNT:   fan_rays     = val[CNT_W-1:0];
            CFG_RAY_SPACING: fan_spacing  = val;
            CFG_HALF_FOV:    fan_half_fov = val;
            CFG_STEP_LEN:    fan_step     = val;
            default: ;
        endcase
    endtask

    task automatic set_fan(input int rays, input int spacing, input int fov, input int len);
        settle();
        write_reg(CFG_RAY_COUNT, REG_W'(rays));
        write_reg(CFG_RAY_SPACING, REG_W'(spacing));
        write_reg(CFG_HALF_FOV, REG_W'(fov));
        write_reg(CFG_STEP_LEN, REG_W'(len));
    endtask

    // Reset settings on an empty grid: rays run out to the border.
    task automatic test_reset_fan();
        send_cast(16'h8000, 16'h8000, 12'd0);
        send_cast(16'h0000, 16'h0000, 12'd4095);
        send_cast(16'hFFFF, 16'hFFFF, 12'd2048);
    endtask

    // Walls set and cleared, and a viewer standing inside a wall cell.
    task automatic test_cell_writes();
        send_cell(4'd8, 4'd9, 1'b1);
        send_cast(16'h8000, 16'h8000, 12'd0);
        send_cell(4'd0, 4'd0, 1'b1);
        send_cell(4'd15, 4'd15, 1'b1);
        send_cell(4'd0, 4'd15, 1'b1);
        send_cell(4'd15, 4'd0, 1'b1);
        send_cast(16'h0800, 16'h0800, 12'd512);
        send_cell(4'd0, 4'd0, 1'b0);
        send_cell(4'd15, 4'd15, 1'b0);
        send_cast(16'h0800, 16'h0800, 12'd512);
    endtask

    // Single rays with the shortest steps, against a wall close by.
    task automatic test_tiny_steps();
        set_fan(1, 0, 0, 1);
        send_cell(4'd0, 4'd1, 1'b1);
        send_cast(16'h0FF0, 16'h0800, 12'd0);
        // A zero count acts as one ray and a zero length as the shortest step.
        set_fan(0, 0, 0, 0);
        send_cast(16'h0FF0, 16'h0800, 12'd0);
        send_cell(4'd1, 4'd0, 1'b1);
        send_cast(16'h0800, 16'h0FF8, 12'd1024);
    endtask

    // Full fans at the register extremes, counts above the maximum clamp to it.
    task automatic test_wide_fans();
        set_fan(64, 4095, 4095, 4095);
        send_cast(16'h8000, 16'h7000, 12'd2048);
        set_fan(127, 0, 2048, 4095);
        send_cast(16'h3456, 16'hC321, 12'd100);
        set_fan(64, 64, 2048, 2000);
        send_cast(16'hA000, 16'h5000, 12'd3000);
    endtask

    // Hold the result side off while casts keep coming, so the input stalls.
    task automatic test_stalled_output();
        set_fan(16, 37, 300, 600);
        hold_left = 600;
        for (int i = 0; i < 4; i++) begin
            send_cast(16'($urandom), 16'($urandom), 12'($urandom));
        end
        settle();
    endtask

    // Random settings per phase, random walls and casts; the last phase never idles.
    task automatic test_random_mix();
        int rays;
        for (int phase = 0; phase < 5; phase++) begin
            rays = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            set_fan(rays, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(150, 4095));
            quiet = (phase == 4);
            for (int i = 0; i < 16; i++) begin
                if ($urandom_range(0, 9) < 4) begin
                    send_cell(4'($urandom), 4'($urandom), $urandom_range(0, 2) != 0);
                end else begin
                    send_cast(16'($urandom), 16'($urandom), 12'($urandom));
                end
            end
        end
    endtask

    // Result side: random stall bursts, a long hold on request, none when quiet.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end else if (stall_left > 0) begin
                m_tready   = 1'b0;
                stall_left = stall_left - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Compare each accepted hit with the oldest one predicted.
    always @(posedge aclk) begin : check_hits
        hit_t want;
        hit_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[5:0], m_tdata[23:6], m_tdata[41:24], m_tlast};
            if (hits_due.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10) begin
                    $display("unexpected hit: ray %0d x %0d y %0d last %0b", got.ray,
                             $signed(got.x), $signed(got.y), got.last);
                end
            end else begin
                want = hits_due.pop_front();
                if (got !== want) begin
                    errors = errors + 1;
                    if (errors <= 10) begin
                        $display("hit mismatch: expected ray %0d x %0d y %0d last %0b",
                                 want.ray, $signed(want.x), $signed(want.y), want.last);
                        $display("              actual   ray %0d x %0d y %0d last %0b",
                                 got.ray, $signed(got.x), $signed(got.y), got.last);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 256; i++) begin
            wall_map[i] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_fan();
        test_cell_writes();
        test_tiny_steps();
        test_wide_fans();
        test_stalled_output();
        test_random_mix();
        settle();

        if (errors == 0 && hits_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/grfm_pkg.sv
rtl/grfm_step_gen.sv
rtl/grid_ray_fan_march_top.sv
dv/testbench.sv
